/* rtl/pmsfp_pkg.sv */
package pmsfp_pkg;

	localparam int unsigned PosW = 5;
	localparam int unsigned ByteW = 8;
	localparam int unsigned WordW = 16;
	localparam int unsigned OutDataW = 56;

	localparam logic [ByteW-1:0] HDR_FIRST  = 8'h42;
	localparam logic [ByteW-1:0] HDR_SECOND = 8'h4D;

	localparam logic [PosW-1:0] POS_HDR0  = 5'd0;
	localparam logic [PosW-1:0] POS_HDR1  = 5'd1;
	localparam logic [PosW-1:0] POS_PM0   = 5'd10;
	localparam logic [PosW-1:0] POS_PM5   = 5'd15;
	localparam logic [PosW-1:0] POS_CHKHI = 5'd22;
	localparam logic [PosW-1:0] POS_LAST  = 5'd23;

	localparam int unsigned PmBytes = 6;

	typedef struct packed {
		logic [WordW-1:0] pm10_value;
		logic [WordW-1:0] pm25_value;
		logic [WordW-1:0] pm1_value;
		logic             frame_good;
		logic [PosW-1:0]  next_position;
	} result_t;

endpackage

/* rtl/pmsfp_parser_core.sv */
module pmsfp_parser_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [pmsfp_pkg::ByteW-1:0]  rx_byte,
	output pmsfp_pkg::result_t           result
);

	logic [pmsfp_pkg::PosW-1:0]  position_q;
	logic [pmsfp_pkg::WordW-1:0] sum_q;
	logic [pmsfp_pkg::ByteW-1:0] pm_bytes_q [pmsfp_pkg::PmBytes];
	logic [pmsfp_pkg::ByteW-1:0] chk_hi_q;
	logic [pmsfp_pkg::WordW-1:0] pm1_q;
	logic [pmsfp_pkg::WordW-1:0] pm25_q;
	logic [pmsfp_pkg::WordW-1:0] pm10_q;

	logic [pmsfp_pkg::PosW-1:0]  pos;
	logic                        hdr_bad;
	logic [pmsfp_pkg::PosW-1:0]  pos_next;
	logic [pmsfp_pkg::WordW-1:0] sum_next;
	logic                        good;
	logic [pmsfp_pkg::WordW-1:0] w1;
	logic [pmsfp_pkg::WordW-1:0] w25;
	logic [pmsfp_pkg::WordW-1:0] w10;
	logic                        in_pm;
	logic [2:0]                  pm_idx;

	always_comb begin
		pos = (position_q > pmsfp_pkg::POS_LAST) ? pmsfp_pkg::POS_HDR0 : position_q;
		hdr_bad = ((pos == pmsfp_pkg::POS_HDR0) && (rx_byte != pmsfp_pkg::HDR_FIRST)) ||
			((pos == pmsfp_pkg::POS_HDR1) && (rx_byte != pmsfp_pkg::HDR_SECOND));

		if (pos == pmsfp_pkg::POS_HDR0) begin
			sum_next = {{(pmsfp_pkg::WordW-pmsfp_pkg::ByteW){1'b0}}, rx_byte};
		end else if (pos < pmsfp_pkg::POS_CHKHI) begin
			sum_next = sum_q + {{(pmsfp_pkg::WordW-pmsfp_pkg::ByteW){1'b0}}, rx_byte};
		end else begin
			sum_next = sum_q;
		end

		in_pm = (pos >= pmsfp_pkg::POS_PM0) && (pos <= pmsfp_pkg::POS_PM5);
		pm_idx = 3'(pos - pmsfp_pkg::POS_PM0);

		w1  = {pm_bytes_q[0], pm_bytes_q[1]};
		w25 = {pm_bytes_q[2], pm_bytes_q[3]};
		w10 = {pm_bytes_q[4], pm_bytes_q[5]};

		good = (pos == pmsfp_pkg::POS_LAST) && ({chk_hi_q, rx_byte} == sum_q);

		if (hdr_bad || (pos == pmsfp_pkg::POS_LAST)) begin
			pos_next = pmsfp_pkg::POS_HDR0;
		end else begin
			pos_next = pos + 5'd1;
		end

		result.next_position = pos_next;
		result.frame_good    = good;
		result.pm1_value     = good ? w1  : pm1_q;
		result.pm25_value    = good ? w25 : pm25_q;
		result.pm10_value    = good ? w10 : pm10_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			sum_q      <= '0;
			pm1_q      <= '0;
			pm25_q     <= '0;
			pm10_q     <= '0;
		end else if (step) begin
			position_q <= pos_next;
			if (!hdr_bad) begin
				sum_q <= sum_next;
			end
			if (good) begin
				pm1_q  <= w1;
				pm25_q <= w25;
				pm10_q <= w10;
			end
		end
	end

	// frame payload bytes, only read after being written in the same frame
	always_ff @(posedge clk) begin
		if (step && !hdr_bad) begin
			if (in_pm) begin
				pm_bytes_q[pm_idx] <= rx_byte;
			end
			if (pos == pmsfp_pkg::POS_CHKHI) begin
				chk_hi_q <= rx_byte;
			end
		end
	end

endmodule

/* rtl/pm_sensor_frame_parser.sv */
// Parser for 24-byte particulate sensor frames (header 0x42 0x4D, 16-bit sum of
// bytes 0..21 checked against the big-endian word in bytes 22..23). Each input
// beat carries one received byte and yields exactly one output beat holding the
// next expected frame position, a frame-good pulse and the three atmospheric PM
// words latched from the last good frame (zero after reset). Throughput is one
// byte per clock while the output side is not stalled: a beat goes through the
// input register, the position/sum update, and the output register. A stalled
// output beat holds the input side.
module pm_sensor_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] next_position, [5] frame_good, [21:6] pm1_value,
	// [37:22] pm25_value, [53:38] pm10_value, [55:54] zero
	output logic [pmsfp_pkg::OutDataW-1:0] m_axis_tdata
);

	logic                        valid_s1;
	logic [pmsfp_pkg::ByteW-1:0] byte_s1;
	logic                        advance;
	pmsfp_pkg::result_t          result;
	logic                        out_valid_q;
	pmsfp_pkg::result_t          out_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	pmsfp_parser_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

	a_good_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_q.frame_good) |-> (out_q.next_position == pmsfp_pkg::POS_HDR0))
		else $error("frame_good without position wrap");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_q.next_position <= pmsfp_pkg::POS_LAST))
		else $error("next_position out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage lost a stalled byte");

endmodule
